/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/lfu_pkg.sv */
// types, constants and helpers shared by the lfu cache modules
package lfu_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request transaction
    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_data;
    } lfu_in_t;

    // response transaction
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_data;
    } lfu_out_t;

    // one stored slot
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] stamp;
    } lfu_entry_t;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } lfu_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic is_get;
        logic out_free;
    } lfu_stat_t;

    // increment that stops at all ones
    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

/* sv/lfu_ram.sv */
// generic single-write, single-read ram with registered read data
module lfu_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/lfu_ctrl.sv */
// sequencing state machine for the lfu cache
module lfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t  cmd
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!stat.is_get || stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.scan = 1'b0;
            end
            ST_COMMIT:
            begin
                cmd.commit = !stat.is_get || stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* sv/lfu_dp.sv */
// datapath: entry ram, slot scan, victim search, update and response register
module lfu_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_data,
    input  lfu_pkg::lfu_in_t            in_data,
    input  lfu_pkg::lfu_cmd_t           cmd,
    output lfu_pkg::lfu_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lfu_pkg::lfu_out_t           out_data
);
    import lfu_pkg::*;

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;
    localparam int EW   = $bits(lfu_entry_t);

    // control state
    logic [ENTRIES-1:0]  valid_reg;
    logic [FW-1:0]       fill_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [DATA_W-1:0]   time_reg;
    logic [IDXW-1:0]     scan_addr_reg;
    logic                rd_pend_reg;
    logic                hit_reg;
    logic                have_reg;
    logic                free_found_reg;
    logic                out_valid_reg;

    // payload state
    lfu_in_t             req_reg;
    logic [IDXW-1:0]     rd_idx_reg;
    logic [IDXW-1:0]     hit_idx_reg;
    lfu_entry_t          hit_ent_reg;
    logic [IDXW-1:0]     best_idx_reg;
    lfu_entry_t          best_ent_reg;
    logic [IDXW-1:0]     free_idx_reg;
    lfu_out_t            out_data_reg;

    logic [EW-1:0]       ram_rdata;
    lfu_entry_t          rd_ent;
    logic                rd_vld;
    logic                key_eq;
    logic                worse;
    logic                out_free;

    logic [CMPW-1:0]     cap_eff;
    logic                evict;
    logic [DATA_W-1:0]   stamp_new;
    logic                wr_en;
    logic [IDXW-1:0]     wr_slot;
    lfu_entry_t          wr_ent;
    logic                put_new;

    lfu_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IDXW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_slot),
        .wdata (wr_ent),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // compare the slot coming back from the ram
    always_comb
    begin
        rd_ent = lfu_entry_t'(ram_rdata);
        rd_vld = rd_pend_reg && valid_reg[rd_idx_reg];
        key_eq = (rd_ent.key == req_reg.lookup_key);
        if (rd_ent.count != best_ent_reg.count)
        begin
            worse = rd_ent.count < best_ent_reg.count;
        end
        else if (rd_ent.stamp != best_ent_reg.stamp)
        begin
            worse = rd_ent.stamp < best_ent_reg.stamp;
        end
        else
        begin
            worse = $signed(rd_ent.key) < $signed(best_ent_reg.key);
        end
    end

    // clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMPW'(1);
        end
        else if (CMPW'(cap_reg) > CMPW'(ENTRIES))
        begin
            cap_eff = CMPW'(ENTRIES);
        end
        else
        begin
            cap_eff = CMPW'(cap_reg);
        end
        evict = CMPW'(fill_reg) >= cap_eff;
    end

    // update of the chosen slot
    always_comb
    begin
        stamp_new = sat_inc(time_reg);
        put_new   = 1'b0;
        wr_slot   = hit_idx_reg;
        wr_ent    = hit_ent_reg;
        wr_en     = 1'b0;
        if (hit_reg)
        begin
            wr_ent.count = sat_inc(hit_ent_reg.count);
            wr_ent.stamp = stamp_new;
            if (req_reg.mode == MODE_PUT)
            begin
                wr_ent.data = req_reg.write_data;
            end
            wr_en = cmd.commit;
        end
        else if (req_reg.mode == MODE_PUT)
        begin
            wr_slot      = evict ? best_idx_reg : free_idx_reg;
            wr_ent.key   = req_reg.lookup_key;
            wr_ent.data  = req_reg.write_data;
            wr_ent.count = DATA_W'(1);
            wr_ent.stamp = stamp_new;
            put_new      = cmd.commit && (evict ? have_reg : free_found_reg);
            wr_en        = put_new;
        end
    end

    assign out_free       = !out_valid_reg || !out_stall;
    assign stat.scan_last = (scan_addr_reg == IDXW'(ENTRIES - 1));
    assign stat.is_get    = (req_reg.mode == MODE_GET);
    assign stat.out_free  = out_free;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fill_reg       <= '0;
            cap_reg        <= CAP_RESET;
            time_reg       <= '0;
            scan_addr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            have_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            rd_pend_reg <= cmd.scan;
            if (cmd.start)
            begin
                scan_addr_reg  <= '0;
                hit_reg        <= 1'b0;
                have_reg       <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !stat.scan_last)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (rd_vld && key_eq)
                begin
                    hit_reg <= 1'b1;
                end
                if (rd_vld)
                begin
                    have_reg <= 1'b1;
                end
                if (rd_pend_reg && !valid_reg[rd_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            // slot update
            if (wr_en)
            begin
                time_reg <= stamp_new;
            end
            if (put_new)
            begin
                valid_reg[wr_slot] <= 1'b1;
                if (!evict)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            // response register
            if (cmd.commit && stat.is_get)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= in_data;
        end
        rd_idx_reg <= scan_addr_reg;
        // first matching slot
        if (rd_vld && key_eq && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_ent_reg <= rd_ent;
        end
        // victim: lowest count, then oldest stamp, then smallest key
        if (rd_vld && (!have_reg || worse))
        begin
            best_idx_reg <= rd_idx_reg;
            best_ent_reg <= rd_ent;
        end
        // lowest free slot
        if (rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit && stat.is_get)
        begin
            out_data_reg.found     <= hit_reg;
            out_data_reg.read_data <= hit_reg ? hit_ent_reg.data : '1;
        end
    end

endmodule

/* sv/lfu_cache.sv */
// lfu_cache: key-value store with least-frequently-used replacement
//
// Request channel in_valid / in_stall / in_data carries a get (mode 0) or a
// put (mode 1). A get produces one response transaction on out_valid /
// out_stall / out_data (found, read_data; read_data is all ones on a miss).
// A put produces no response. Capacity is written on cfg_valid / cfg_ready
// (cfg_ready is always high) and must only change while the cache is idle.
//
// Each request runs from accept to the next accept through the scan, drain,
// commit and idle states: the entry ram has a single read port and is
// scanned one slot per cycle for the key match, the victim and the first
// free slot, then the drain state takes the last read, the commit state
// writes the slot and the idle state accepts the next request.
// A get response is loaded into the response register in the commit state.
//
// Reset clears all valid marks, the fill count and the global time, and sets
// the capacity to 16. While out_stall is high the response is held; a
// following request is still accepted and worked on, and a second get waits
// in its write-back cycle until the held response is taken.
module lfu_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lfu_pkg::lfu_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lfu_pkg::lfu_out_t           out_data
);
    import lfu_pkg::*;

    lfu_cmd_t  cmd;
    lfu_stat_t stat;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfu_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sv/lfu_chk.sv */
// port-level checker for the lfu cache, bound to the top level
`include "assert_macros.svh"

module lfu_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input lfu_pkg::lfu_out_t           out_data
);

    // configuration is never back-pressured
    `CHK_IMPLY(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

    // an accepted request keeps the cache busy in the next cycle
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // no response can appear in the cycle after a request is accepted
    `CHK_NEXT(a_no_early_resp, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

    // a new response comes only as the cache returns to idle
    `CHK_IMPLY(a_resp_at_idle, clk, rst_n, $rose(out_valid), !in_stall)

    // a stalled response holds
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind lfu_cache lfu_chk u_chk (.*);
